FILE: src/mer_pkg.sv
package mer_pkg;

    localparam int AXIS_BITS_DEF  = 10;
    localparam int COORD_BITS_DEF = 13;
    localparam int OUT_TDATA_W    = ((2 * COORD_BITS_DEF + 7) / 8) * 8;

    localparam int CENTER_W   = 12;
    localparam int CLIP_W     = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SEMI_X   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEMI_Y   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CLIP_X   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CLIP_Y   = 3'd5;

    localparam logic [CLIP_W-1:0] CLIP_X_RESET = 12'd40;
    localparam logic [CLIP_W-1:0] CLIP_Y_RESET = 12'd30;

    typedef struct packed {
        logic mul_en;
        logic sub;
    } t_arith_ctl;

endpackage

FILE: src/mer_arith.sv
module mer_arith #(
    parameter int DW = 41,
    parameter int MA = 20,
    parameter int MB = 14
) (
    input  logic                     i_clk,
    input  mer_pkg::t_arith_ctl      i_ctl,
    input  logic [MA-1:0]            i_mul_a,
    input  logic signed [MB-1:0]     i_mul_b,
    input  logic signed [DW-1:0]     i_add_a,
    input  logic signed [DW-1:0]     i_add_b,
    output logic signed [MA+MB:0]    o_prod,
    output logic signed [DW-1:0]     o_sum
);
    import mer_pkg::*;

    logic signed [MA+MB:0] prod;

    assign prod  = $signed({1'b0, i_mul_a}) * i_mul_b;
    assign o_sum = i_ctl.sub ? (i_add_a - i_add_b) : (i_add_a + i_add_b);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            o_prod <= prod;
        end
    end

endmodule

FILE: src/midpoint_ellipse_rasterizer_core.sv
// Channel   Dir  Handshake                 Payload
// s_*       in   i_s_tvalid / o_s_tready   tdata[0] restart
// m_*       out  o_m_tvalid / i_m_tready   tdata: point_x, point_y; tlast: last_of_step;
//                                          tuser: visible, ellipse_done
// cfg_*     in   i_cfg_we                  i_cfg_addr register index, i_cfg_wdata value
//
// One request at a time; o_s_tready is high only in idle; a finished ellipse stays idle.
// Restart: setup states S0 to S8 on the shared multiplier/adder, an end check, then 4 points.
// Region one step: a check, adder states R1A to R1C, an end check and 4 points; region
// two adds a bottom check, entering it adds multiplier states T0 to T4, the bottom ends
// without points. A point waits in the output register while i_m_tready is low. Reset
// is synchronous: control and configuration take reset values.
module midpoint_ellipse_rasterizer_core #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    input  logic [mer_pkg::IN_TDATA_W-1:0]            i_s_tdata,   // [0] restart
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]         o_m_tdata,   // point_x, point_y
    output logic                                      o_m_tlast,
    output logic [mer_pkg::OUT_TUSER_W-1:0]           o_m_tuser,   // visible, ellipse_done
    input  logic                                      i_cfg_we,
    input  logic [mer_pkg::CFG_ADDR_W-1:0]            i_cfg_addr,
    input  logic [((AXIS_BITS > 12) ? AXIS_BITS : 12)-1:0] i_cfg_wdata
);
    import mer_pkg::*;

    localparam int TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int MA = 2 * AXIS_BITS;
    localparam int MB = AXIS_BITS + 4;
    localparam int PW = MA + MB + 1;
    localparam int DW = 4 * AXIS_BITS + 1;
    localparam int OW = AXIS_BITS + 2;
    localparam int EW = ((OW > CENTER_W) ? OW : CENTER_W) + 1;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_S0    = 5'd1;
    localparam logic [4:0] ST_S1    = 5'd2;
    localparam logic [4:0] ST_S2    = 5'd3;
    localparam logic [4:0] ST_S3    = 5'd4;
    localparam logic [4:0] ST_S4    = 5'd5;
    localparam logic [4:0] ST_S5    = 5'd6;
    localparam logic [4:0] ST_S6    = 5'd7;
    localparam logic [4:0] ST_S7    = 5'd8;
    localparam logic [4:0] ST_S8    = 5'd9;
    localparam logic [4:0] ST_CHK   = 5'd10;
    localparam logic [4:0] ST_R1A   = 5'd11;
    localparam logic [4:0] ST_R1B   = 5'd12;
    localparam logic [4:0] ST_R1C   = 5'd13;
    localparam logic [4:0] ST_T0    = 5'd14;
    localparam logic [4:0] ST_T1    = 5'd15;
    localparam logic [4:0] ST_T2    = 5'd16;
    localparam logic [4:0] ST_T3    = 5'd17;
    localparam logic [4:0] ST_T4    = 5'd18;
    localparam logic [4:0] ST_R2CHK = 5'd19;
    localparam logic [4:0] ST_R2A   = 5'd20;
    localparam logic [4:0] ST_R2B   = 5'd21;
    localparam logic [4:0] ST_R2C   = 5'd22;
    localparam logic [4:0] ST_END   = 5'd23;
    localparam logic [4:0] ST_EMIT  = 5'd24;

    function automatic logic signed [DW-1:0] div4_trunc(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] q;
        q = v >>> 2;
        if (v[DW-1] && (v[1:0] != 2'b00)) begin
            q = q + DW'(1);
        end
        return q;
    endfunction

    // configuration
    logic [CENTER_W-1:0]  r_cx, r_cy;
    logic [AXIS_BITS-1:0] r_a, r_b;
    logic [CLIP_W-1:0]    r_clx, r_cly;

    // sequencer and ellipse state
    logic [4:0]            r_state, n_state;
    logic [MA-1:0]         r_a2, n_a2, r_b2, n_b2;
    logic signed [DW-1:0]  r_dec, n_dec, r_str, n_str, r_diag, n_diag;
    logic signed [DW-1:0]  r_thr, n_thr, r_inc2, n_inc2, r_tmp, n_tmp;
    logic signed [OW-1:0]  r_x, n_x, r_y, n_y;
    logic                  r_reg2, n_reg2, r_fin, n_fin, r_done, n_done, r_br, n_br;
    logic [1:0]            r_pt, n_pt;

    // output register
    logic                  r_m_valid, n_m_valid;
    logic [COORD_BITS-1:0] r_m_px, n_m_px, r_m_py, n_m_py;
    logic                  r_m_vis, n_m_vis, r_m_last, n_m_last, r_m_done, n_m_done;

    // shared unit
    t_arith_ctl            arith_ctl;
    logic [MA-1:0]         mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [DW-1:0]  add_a, add_b, sum;
    logic signed [PW-1:0]  prod;
    logic signed [DW-1:0]  prod_w;

    logic signed [DW-1:0]  a2_w, b2_w, two_a2, two_b2;
    logic signed [MB-1:0]  a_s, b_s, x_s, y_s;
    logic                  dec_neg, dec_pos, diag_lt_thr, load_out;

    logic signed [EW-1:0]  cx_e, cy_e, x_e, y_e, px, py, abs_px, abs_py, clx_e, cly_e;
    logic                  pt_vis;

    mer_arith #(
        .DW (DW),
        .MA (MA),
        .MB (MB)
    ) u_mer_arith (
        .i_clk   (i_clk),
        .i_ctl   (arith_ctl),
        .i_mul_a (mul_a),
        .i_mul_b (mul_b),
        .i_add_a (add_a),
        .i_add_b (add_b),
        .o_prod  (prod),
        .o_sum   (sum)
    );

    assign prod_w = DW'(prod);
    assign a2_w   = DW'({1'b0, r_a2});
    assign b2_w   = DW'({1'b0, r_b2});
    assign two_a2 = a2_w <<< 1;
    assign two_b2 = b2_w <<< 1;
    assign a_s    = MB'({1'b0, r_a});
    assign b_s    = MB'({1'b0, r_b});
    assign x_s    = MB'(r_x);
    assign y_s    = MB'(r_y);

    assign dec_neg     = r_dec[DW-1];
    assign dec_pos     = !r_dec[DW-1] && (r_dec != '0);
    assign diag_lt_thr = r_diag < r_thr;
    assign load_out    = !r_m_valid || i_m_tready;

    // mirrored point: bit 0 of the index flips x, bit 1 flips y
    always_comb begin
        cx_e   = EW'($signed(r_cx));
        cy_e   = EW'($signed(r_cy));
        x_e    = EW'(r_x);
        y_e    = EW'(r_y);
        clx_e  = EW'({1'b0, r_clx});
        cly_e  = EW'({1'b0, r_cly});
        px     = r_pt[0] ? (cx_e - x_e) : (cx_e + x_e);
        py     = r_pt[1] ? (cy_e - y_e) : (cy_e + y_e);
        abs_px = px[EW-1] ? -px : px;
        abs_py = py[EW-1] ? -py : py;
        pt_vis = (abs_px < clx_e) && (abs_py < cly_e);
    end

    always_comb begin
        n_state   = r_state;
        n_a2      = r_a2;
        n_b2      = r_b2;
        n_dec     = r_dec;
        n_str     = r_str;
        n_diag    = r_diag;
        n_thr     = r_thr;
        n_inc2    = r_inc2;
        n_tmp     = r_tmp;
        n_x       = r_x;
        n_y       = r_y;
        n_reg2    = r_reg2;
        n_fin     = r_fin;
        n_done    = r_done;
        n_br      = r_br;
        n_pt      = r_pt;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_px    = r_m_px;
        n_m_py    = r_m_py;
        n_m_vis   = r_m_vis;
        n_m_last  = r_m_last;
        n_m_done  = r_m_done;
        arith_ctl = '0;
        mul_a     = '0;
        mul_b     = '0;
        add_a     = '0;
        add_b     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tdata[0]) begin
                        n_state = ST_S0;
                    end else if (!r_fin) begin
                        n_state = ST_CHK;
                    end
                end
            end
            ST_S0: begin
                arith_ctl.mul_en = 1'b1;
                mul_a            = MA'(r_a);
                mul_b            = a_s;
                n_state          = ST_S1;
            end
            ST_S1: begin
                n_a2             = prod[MA-1:0];
                arith_ctl.mul_en = 1'b1;
                mul_a            = MA'(r_b);
                mul_b            = b_s;
                n_state          = ST_S2;
            end
            ST_S2: begin
                n_b2             = prod[MA-1:0];
                arith_ctl.mul_en = 1'b1;
                mul_a            = r_a2;
                mul_b            = MB'(1) - (b_s <<< 2);
                n_state          = ST_S3;
            end
            ST_S3: begin
                add_a            = prod_w;
                add_b            = DW'(2);
                arith_ctl.sub    = 1'b1;
                n_tmp            = sum;
                arith_ctl.mul_en = 1'b1;
                mul_a            = r_a2;
                mul_b            = MB'(2) - (b_s <<< 1);
                n_state          = ST_S4;
            end
            ST_S4: begin
                add_a   = two_b2;
                add_b   = b2_w;
                n_str   = sum;
                n_state = ST_S5;
            end
            ST_S5: begin
                add_a   = r_str;
                add_b   = prod_w;
                n_diag  = sum;
                n_state = ST_S6;
            end
            ST_S6: begin
                add_a   = b2_w;
                add_b   = div4_trunc(r_tmp);
                n_dec   = sum;
                n_state = ST_S7;
            end
            ST_S7: begin
                // region one ends once the diagonal increment reaches this
                add_a   = r_str;
                add_b   = two_a2;
                n_thr   = sum;
                n_state = ST_S8;
            end
            ST_S8: begin
                add_a   = two_a2;
                add_b   = two_b2;
                n_inc2  = sum;
                n_x     = '0;
                n_y     = OW'({1'b0, r_b});
                n_reg2  = 1'b0;
                n_fin   = 1'b0;
                n_state = ST_END;
            end
            ST_CHK: begin
                if (!r_reg2 && diag_lt_thr) begin
                    n_state = ST_R1A;
                end else if (!r_reg2) begin
                    n_state = ST_T0;
                end else begin
                    n_state = ST_R2CHK;
                end
            end
            ST_R1A: begin
                n_br    = dec_neg;
                add_a   = r_dec;
                add_b   = dec_neg ? r_str : r_diag;
                n_dec   = sum;
                n_x     = r_x + OW'(1);
                if (!dec_neg) begin
                    n_y = r_y - OW'(1);
                end
                n_state = ST_R1B;
            end
            ST_R1B: begin
                add_a   = r_str;
                add_b   = two_b2;
                n_str   = sum;
                n_state = ST_R1C;
            end
            ST_R1C: begin
                add_a   = r_diag;
                add_b   = r_br ? two_b2 : r_inc2;
                n_diag  = sum;
                n_state = ST_END;
            end
            ST_T0: begin
                arith_ctl.mul_en = 1'b1;
                mul_a            = r_a2;
                mul_b            = (y_s <<< 2) - MB'(3);
                n_state          = ST_T1;
            end
            ST_T1: begin
                add_a            = prod_w;
                add_b            = DW'(2);
                n_tmp            = sum;
                arith_ctl.mul_en = 1'b1;
                mul_a            = r_b2;
                mul_b            = (x_s <<< 2) + MB'(3);
                n_state          = ST_T2;
            end
            ST_T2: begin
                add_a            = r_tmp;
                add_b            = prod_w;
                n_tmp            = sum;
                arith_ctl.mul_en = 1'b1;
                mul_a            = r_a2;
                mul_b            = MB'(3) - (y_s <<< 1);
                n_state          = ST_T3;
            end
            ST_T3: begin
                add_a            = r_dec;
                add_b            = div4_trunc(r_tmp);
                arith_ctl.sub    = 1'b1;
                n_dec            = sum;
                n_str            = prod_w;
                arith_ctl.mul_en = 1'b1;
                mul_a            = r_b2;
                mul_b            = (x_s <<< 1) + MB'(2);
                n_state          = ST_T4;
            end
            ST_T4: begin
                add_a   = r_str;
                add_b   = prod_w;
                n_diag  = sum;
                n_reg2  = 1'b1;
                n_state = ST_R2CHK;
            end
            ST_R2CHK: begin
                // bottom reached: end without points
                if (r_y <= OW'(0)) begin
                    n_fin   = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_R2A;
                end
            end
            ST_R2A: begin
                n_br    = dec_pos;
                add_a   = r_dec;
                add_b   = dec_pos ? r_str : r_diag;
                n_dec   = sum;
                n_y     = r_y - OW'(1);
                if (!dec_pos) begin
                    n_x = r_x + OW'(1);
                end
                n_state = ST_R2B;
            end
            ST_R2B: begin
                add_a   = r_str;
                add_b   = two_a2;
                n_str   = sum;
                n_state = ST_R2C;
            end
            ST_R2C: begin
                add_a   = r_diag;
                add_b   = r_br ? two_a2 : r_inc2;
                n_diag  = sum;
                n_state = ST_END;
            end
            ST_END: begin
                n_done  = (r_y == OW'(0)) && (r_reg2 || !diag_lt_thr);
                n_pt    = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (load_out) begin
                    n_m_valid = 1'b1;
                    n_m_px    = COORD_BITS'(px);
                    n_m_py    = COORD_BITS'(py);
                    n_m_vis   = pt_vis;
                    n_m_last  = (r_pt == 2'd3);
                    n_m_done  = r_done;
                    n_pt      = r_pt + 2'd1;
                    if (r_pt == 2'd3) begin
                        n_fin   = r_fin || r_done;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_reg2    <= 1'b0;
            r_fin     <= 1'b1;
            r_m_valid <= 1'b0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_a       <= AXIS_BITS'(1);
            r_b       <= AXIS_BITS'(1);
            r_clx     <= CLIP_X_RESET;
            r_cly     <= CLIP_Y_RESET;
        end else begin
            r_state   <= n_state;
            r_reg2    <= n_reg2;
            r_fin     <= n_fin;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_CENTER_X: r_cx  <= i_cfg_wdata[CENTER_W-1:0];
                    REG_CENTER_Y: r_cy  <= i_cfg_wdata[CENTER_W-1:0];
                    REG_SEMI_X:   r_a   <= i_cfg_wdata[AXIS_BITS-1:0];
                    REG_SEMI_Y:   r_b   <= i_cfg_wdata[AXIS_BITS-1:0];
                    REG_CLIP_X:   r_clx <= i_cfg_wdata[CLIP_W-1:0];
                    REG_CLIP_Y:   r_cly <= i_cfg_wdata[CLIP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a2     <= n_a2;
        r_b2     <= n_b2;
        r_dec    <= n_dec;
        r_str    <= n_str;
        r_diag   <= n_diag;
        r_thr    <= n_thr;
        r_inc2   <= n_inc2;
        r_tmp    <= n_tmp;
        r_x      <= n_x;
        r_y      <= n_y;
        r_done   <= n_done;
        r_br     <= n_br;
        r_pt     <= n_pt;
        r_m_px   <= n_m_px;
        r_m_py   <= n_m_py;
        r_m_vis  <= n_m_vis;
        r_m_last <= n_m_last;
        r_m_done <= n_m_done;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = TDATA_W'({r_m_py, r_m_px});
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = {r_m_done, r_m_vis};

endmodule

FILE: src/mer_checker.sv
module mer_checker #(
    parameter int TDATA_W = mer_pkg::OUT_TDATA_W
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [mer_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [TDATA_W-1:0]               o_m_tdata,
    input logic                             o_m_tlast,
    input logic [mer_pkg::OUT_TUSER_W-1:0]  o_m_tuser
);

    // nothing leaves the output register right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a held point keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled point changed");

    // a restart request keeps the block busy for its setup
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[0] |=> !o_s_tready)
        else $error("request accepted while previous still in work");

    // the four points of a step follow each other without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside a group of four points");

    // ellipse_done is the same on all points of a step
    a_done_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tuser[1] == $past(o_m_tuser[1]))
        else $error("done flag changed inside a step");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker #(.TDATA_W(TDATA_W)) u_mer_checker (.*);
